### src/abps_pkg.sv
// shared types and constants for the alpha blend pixel store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package abps_pkg;

  localparam int TILE_SIZE = 256;
  localparam int TILE_BITS = $clog2(TILE_SIZE);
  localparam int ADDR_W    = 2 * TILE_BITS;
  localparam int DIV_W     = 32;
  localparam int ALPHA_W   = 17;
  localparam int NUM_W     = 25;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OPACITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RGB_ONLY = CFG_IDX_W'(1);

  localparam logic KIND_BLEND = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // source alpha scaling: divide by 255*255 through a reciprocal, floor(2^32 / 65025)
  localparam logic [ALPHA_W-1:0] SA_DIVISOR = ALPHA_W'(65025);
  localparam logic [ALPHA_W-1:0] SA_RECIP   = ALPHA_W'(66051);

  typedef struct packed {
    logic       clr_wr;
    logic       cap;
    logic       mem_rd;
    logic       set_res;
    logic       div_start;
    logic       ld_sa;
    logic       fix_sa;
    logic       ld_da;
    logic       ld_dw;
    logic       ld_oa;
    logic       mul_s;
    logic       mul_d;
    logic       ld_ch;
    logic       ld_alpha;
    logic       mem_wr;
    logic       out_valid;
  } abps_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic write_back;
    logic rgb_mode;
    logic div_done;
    logic oa_zero;
    logic ch_last;
  } abps_stat_t;

endpackage
`default_nettype wire

### src/abps_div.sv
// restoring divider, one quotient bit per cycle
// depends on abps_pkg
`timescale 1ns / 1ps
`default_nettype none
module abps_div
  import abps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_W-1:0]   dividend,
  input  wire logic [ALPHA_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [ALPHA_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [ALPHA_W:0]   trial, diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(DIV_W);
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ALPHA_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ALPHA_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### src/abps_dp.sv
// datapath: pixel memory, config registers, blend arithmetic and result register
// depends on abps_pkg and abps_div
`timescale 1ns / 1ps
`default_nettype none
module abps_dp
  import abps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire abps_cmd_t            cmd,
  output abps_stat_t                stat,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_kind,
  input  wire logic signed [15:0]   in_pos_x,
  input  wire logic signed [15:0]   in_pos_y,
  input  wire logic [7:0]           in_src_red,
  input  wire logic [7:0]           in_src_green,
  input  wire logic [7:0]           in_src_blue,
  input  wire logic [7:0]           in_src_alpha,
  output logic                      res_in_tile,
  output logic [31:0]               res_pixel
);

  logic [31:0]        mem [TILE_SIZE*TILE_SIZE];
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [7:0]         opacity_r;
  logic               rgb_only_r;
  logic               kind_r, tile_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [7:0]         src_r [3];
  logic [15:0]        prod_ao_r;
  logic [31:0]        px_r, res_r, res_dec;
  logic [ALPHA_W-1:0] sa_r, da_r, dw_r, oa_r;
  logic [NUM_W-1:0]   num_r;
  logic [1:0]         ch_idx_r;
  logic               tile_in;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [ALPHA_W-1:0] div_divisor;
  logic               div_done;
  logic [7:0]         cs, cd, ch_val;
  logic [ALPHA_W:0]   one_minus_sa;
  logic [2*ALPHA_W+1:0] dw_prod;
  logic [NUM_W-1:0]   alpha_prod;
  logic [DIV_W-1:0]   sa_prod;
  logic [DIV_W+1:0]   sa_rem;
  logic [ALPHA_W-1:0] sa_fix, da_val;

  assign tile_in = !in_pos_x[15] && (in_pos_x[14:0] < 15'(TILE_SIZE))
                && !in_pos_y[15] && (in_pos_y[14:0] < 15'(TILE_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r  <= 8'd255;
      rgb_only_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPACITY:  opacity_r  <= cfg_data;
          REG_RGB_ONLY: rgb_only_r <= cfg_data[0];
          default:      ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.mem_wr) begin
      mem[addr_r] <= res_r;
    end
    if (cmd.mem_rd) begin
      px_r <= mem[addr_r];
    end
  end

  always_comb begin
    if (!tile_r) begin
      res_dec = '0;
    end else if (kind_r == KIND_READ) begin
      res_dec = px_r;
    end else if (rgb_only_r) begin
      res_dec = {px_r[31:24], src_r[2], src_r[1], src_r[0]};
    end else begin
      res_dec = px_r;   // also the result when the output alpha is zero
    end
  end

  always_comb begin
    div_dividend = DIV_W'(num_r);
    div_divisor  = oa_r;
  end

  abps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // source alpha estimate is at most one low, the next step corrects it
  always_comb begin
    sa_prod = prod_ao_r * SA_RECIP;
    sa_rem  = {2'b00, prod_ao_r, 16'd0} - (DIV_W+2)'(sa_r) * (DIV_W+2)'(SA_DIVISOR);
    sa_fix  = (sa_rem >= (DIV_W+2)'(SA_DIVISOR)) ? sa_r + ALPHA_W'(1) : sa_r;
    // a * 65536 / 255 is a * 257 plus one only for full alpha
    da_val  = {1'b0, px_r[31:24], px_r[31:24]} + ALPHA_W'(px_r[31:24] == 8'hff);
  end

  always_comb begin
    case (ch_idx_r)
      2'd0:    cd = px_r[7:0];
      2'd1:    cd = px_r[15:8];
      default: cd = px_r[23:16];
    endcase
    cs           = src_r[ch_idx_r];
    ch_val       = (div_quo > DIV_W'(255)) ? 8'd255 : div_quo[7:0];
    one_minus_sa = (ALPHA_W+1)'(65536) - {1'b0, sa_r};
    dw_prod      = {1'b0, da_r} * one_minus_sa;
    alpha_prod   = NUM_W'(oa_r) * NUM_W'(255);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r    <= in_kind;
      tile_r    <= tile_in;
      addr_r    <= {in_pos_y[TILE_BITS-1:0], in_pos_x[TILE_BITS-1:0]};
      src_r[0]  <= in_src_red;
      src_r[1]  <= in_src_green;
      src_r[2]  <= in_src_blue;
      prod_ao_r <= in_src_alpha * opacity_r;
    end
    if (cmd.ld_sa)  sa_r <= {1'b0, sa_prod[31:16]};
    if (cmd.fix_sa) sa_r <= sa_fix;
    if (cmd.ld_da)  da_r <= da_val;
    if (cmd.ld_dw)  dw_r <= dw_prod[ALPHA_W+15:16];
    if (cmd.ld_oa)  oa_r <= sa_r + dw_r;
    if (cmd.mul_s)  num_r <= NUM_W'(cs) * NUM_W'(sa_r);
    if (cmd.mul_d)  num_r <= num_r + NUM_W'(cd) * NUM_W'(dw_r);
    if (cmd.set_res) begin
      res_r    <= res_dec;
      ch_idx_r <= 2'd0;
    end
    if (cmd.ld_ch) begin
      case (ch_idx_r)
        2'd0:    res_r[7:0]   <= ch_val;
        2'd1:    res_r[15:8]  <= ch_val;
        default: res_r[23:16] <= ch_val;
      endcase
      ch_idx_r <= ch_idx_r + 2'd1;
    end
    if (cmd.ld_alpha) begin
      res_r[31:24] <= alpha_prod[23:16];
    end
  end

  always_comb begin
    stat.clr_last   = &clr_cnt_r;
    stat.write_back = tile_r && (kind_r == KIND_BLEND);
    stat.rgb_mode   = rgb_only_r;
    stat.div_done   = div_done;
    stat.oa_zero    = (sa_r == '0) && (dw_r == '0);
    stat.ch_last    = (ch_idx_r == 2'd2);
  end

  assign res_in_tile = tile_r;
  assign res_pixel   = res_r;

endmodule
`default_nettype wire

### src/abps_ctrl.sv
// controller state machine sequencing clear, read, blend steps and result strobe
// depends on abps_pkg
`timescale 1ns / 1ps
`default_nettype none
module abps_ctrl
  import abps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire abps_stat_t stat,
  output abps_cmd_t       cmd,
  output logic            busy
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_DSA  = 4'd4;
  localparam logic [3:0] S_DDA  = 4'd5;
  localparam logic [3:0] S_DW   = 4'd6;
  localparam logic [3:0] S_OA   = 4'd7;
  localparam logic [3:0] S_MS   = 4'd8;
  localparam logic [3:0] S_MD   = 4'd9;
  localparam logic [3:0] S_DGO  = 4'd10;
  localparam logic [3:0] S_DCH  = 4'd11;
  localparam logic [3:0] S_ALP  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        cmd.set_res = 1'b1;
        if (stat.write_back && !stat.rgb_mode) begin
          state_nxt = S_DSA;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DSA: begin
        cmd.ld_sa = 1'b1;
        state_nxt = S_DDA;
      end
      S_DDA: begin
        cmd.fix_sa = 1'b1;
        cmd.ld_da  = 1'b1;
        state_nxt  = S_DW;
      end
      S_DW: begin
        cmd.ld_dw = 1'b1;
        state_nxt = S_OA;
      end
      S_OA: begin
        cmd.ld_oa = 1'b1;
        state_nxt = stat.oa_zero ? S_OUT : S_MS;
      end
      S_MS: begin
        cmd.mul_s = 1'b1;
        state_nxt = S_MD;
      end
      S_MD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DCH;
      end
      S_DCH: begin
        if (stat.div_done) begin
          cmd.ld_ch = 1'b1;
          state_nxt = stat.ch_last ? S_ALP : S_MS;
        end
      end
      S_ALP: begin
        cmd.ld_alpha = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        cmd.out_valid = 1'b1;
        cmd.mem_wr    = stat.write_back;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

### src/alpha_blend_pixel_store.sv
// top level of the alpha blend pixel store: controller plus datapath
// depends on abps_pkg, abps_ctrl, abps_dp
`timescale 1ns / 1ps
`default_nettype none
// A tile of 256 x 256 RGBA8 pixels. After reset the block clears the tile, one
// pixel a cycle, with busy high; configuration writes are taken at any time
// (cfg_ready is always high) but should only be made while idle.
// An item is taken when start is high and busy low, and one item is worked on at
// a time. Its result appears on the out_ ports for a single cycle with out_valid
// high and cannot be held off. A read, an RGB overwrite or a coordinate outside
// the tile goes from capture through the memory read and decode to the result,
// and a blend whose output alpha is zero adds the source alpha scaling and the
// destination weight and output alpha steps. Any other four-channel blend also
// runs the shared 32-step divider, once per colour channel after its multiply
// steps, plus the memory read and the two-step source alpha scaling.
module alpha_blend_pixel_store
  import abps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_kind,
  input  wire logic signed [15:0]   in_pos_x,
  input  wire logic signed [15:0]   in_pos_y,
  input  wire logic [7:0]           in_src_red,
  input  wire logic [7:0]           in_src_green,
  input  wire logic [7:0]           in_src_blue,
  input  wire logic [7:0]           in_src_alpha,
  output logic                      out_valid,
  output logic                      out_in_tile,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  abps_cmd_t   cmd;
  abps_stat_t  stat;
  logic [31:0] pixel;

  abps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  abps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (in_kind),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .res_in_tile  (out_in_tile),
    .res_pixel    (pixel)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.out_valid;
  assign out_red   = pixel[7:0];
  assign out_green = pixel[15:8];
  assign out_blue  = pixel[23:16];
  assign out_alpha = pixel[31:24];

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted without going busy");

  a_outside_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_tile |-> (pixel == '0))
    else $error("outside item returned a non-zero pixel");

  a_no_clear_write : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !cmd.mem_wr && !out_valid)
    else $error("clear pass overlaps an item");

endmodule
`default_nettype wire

### bench/alpha_blend_pixel_store_tb.sv
// testbench for the alpha blend pixel store: directed and random items checked
// against a predictor of the tile built into the bench; depends on abps_pkg and alpha_blend_pixel_store
`timescale 1ns / 1ps
`default_nettype none
module alpha_blend_pixel_store_tb
  import abps_pkg::*;
();

  typedef struct packed {
    logic              kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [7:0]        a;
  } blend_item_t;

  typedef struct packed {
    logic       in_tile;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_res_t;

  localparam int STALL_LIMIT = 300000;
  localparam int EXP_DEPTH   = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic [7:0] in_src_red = '0, in_src_green = '0, in_src_blue = '0, in_src_alpha = '0;
  logic out_valid, out_in_tile;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic [31:0] tile_model [0:TILE_SIZE*TILE_SIZE-1];
  logic [7:0]  opacity_q;
  logic        rgb_only_q;
  pixel_res_t  exp_buf [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  always #10 clk = ~clk;

  alpha_blend_pixel_store u_top (
    .clk, .rst_n, .start, .busy, .in_kind, .in_pos_x, .in_pos_y,
    .in_src_red, .in_src_green, .in_src_blue, .in_src_alpha,
    .out_valid, .out_in_tile, .out_red, .out_green, .out_blue, .out_alpha,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // non-premultiplied source-over in 1.16 fixed point
  function automatic logic [31:0] blend_pixel(logic [31:0] dst, blend_item_t it);
    logic [63:0] sa, da, dw, oa, v;
    logic [7:0]  cs [3];
    logic [31:0] res;
    cs[0] = it.r; cs[1] = it.g; cs[2] = it.b;
    sa = (64'(it.a) * 64'(opacity_q) * 64'd65536) / 64'd65025;
    da = (64'(dst[31:24]) * 64'd65536) / 64'd255;
    dw = (da * (64'd65536 - sa)) / 64'd65536;
    oa = sa + dw;
    if (oa == 0) return dst;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      v = (64'(cs[c]) * sa + 64'(dst[8*c +: 8]) * dw) / oa;
      res[8*c +: 8] = (v > 255) ? 8'd255 : v[7:0];
    end
    v = (oa * 255) / 64'd65536;
    res[31:24] = (v > 255) ? 8'd255 : v[7:0];
    return res;
  endfunction

  function automatic pixel_res_t predict_pixel(blend_item_t it);
    int unsigned addr;
    logic [31:0] px;
    pixel_res_t  res;
    res = '0;
    if (it.px < 0 || it.px >= TILE_SIZE || it.py < 0 || it.py >= TILE_SIZE) return res;
    addr = int'(it.py) * TILE_SIZE + int'(it.px);
    px = tile_model[addr];
    if (it.kind == KIND_BLEND) begin
      if (rgb_only_q) px = {px[31:24], it.b, it.g, it.r};
      else px = blend_pixel(px, it);
      tile_model[addr] = px;
    end
    res.in_tile = 1'b1;
    {res.a, res.b, res.g, res.r} = px;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_res_t want;
    if (rst_n && out_valid) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected item, in_tile", out_in_tile, 0);
      end else begin
        want = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_in_tile !== want.in_tile) report_mismatch("in_tile", out_in_tile, want.in_tile);
        if (out_red !== want.r)   report_mismatch("red", out_red, want.r);
        if (out_green !== want.g) report_mismatch("green", out_green, want.g);
        if (out_blue !== want.b)  report_mismatch("blue", out_blue, want.b);
        if (out_alpha !== want.a) report_mismatch("alpha", out_alpha, want.a);
      end
    end
  end

  // watchdog on cycles with no traffic at all (covers the clearing pass)
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("alpha_blend_pixel_store verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start is never lowered in the same step it is raised
  task automatic send_item(blend_item_t it);
    if (!calm && $urandom_range(99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= it.kind;
    in_pos_x <= it.px;
    in_pos_y <= it.py;
    in_src_red <= it.r;
    in_src_green <= it.g;
    in_src_blue <= it.b;
    in_src_alpha <= it.a;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_buf[exp_wr % EXP_DEPTH] = predict_pixel(it);
    exp_wr++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OPACITY) opacity_q = data;
    else if (idx == REG_RGB_ONLY) rgb_only_q = data[0];
    @(posedge clk);
  endtask

  function automatic blend_item_t make_item(logic kind, int x, int y,
                                            logic [31:0] rgba);
    blend_item_t it;
    it.kind = kind;
    it.px = 16'(x);
    it.py = 16'(y);
    {it.a, it.b, it.g, it.r} = rgba;
    return it;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic blend_item_t random_item();
    blend_item_t it;
    int sel;
    it.kind = ($urandom_range(3) == 0) ? KIND_READ : KIND_BLEND;
    sel = $urandom_range(99);
    // mostly a small window so pixels are blended over and over
    if (sel < 70) begin
      it.px = 16'($urandom_range(7));
      it.py = 16'($urandom_range(7));
    end else if (sel < 80) begin
      it.px = 16'($urandom_range(TILE_SIZE - 1));
      it.py = 16'($urandom_range(TILE_SIZE - 1));
    end else if (sel < 88) begin
      it.px = 16'($urandom_range(TILE_SIZE + 1) - 1);
      it.py = 16'($urandom_range(TILE_SIZE + 1) - 1);
    end else begin
      it.px = 16'($urandom);
      it.py = 16'($urandom);
    end
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    it.a = pick_alpha();
    return it;
  endfunction

  task automatic test_directed_rgba();
    send_item(make_item(KIND_READ, 0, 0, 32'h0));
    send_item(make_item(KIND_BLEND, 0, 0, 32'h00_ff_80_40));     // zero output alpha
    send_item(make_item(KIND_BLEND, 0, 0, 32'hff_ff_ff_ff));
    send_item(make_item(KIND_BLEND, 0, 0, 32'h80_00_00_00));
    send_item(make_item(KIND_BLEND, 0, 0, 32'h01_12_34_56));
    send_item(make_item(KIND_READ, 0, 0, 32'hffffffff));
    send_item(make_item(KIND_BLEND, 255, 255, 32'h7f_aa_55_01));
    send_item(make_item(KIND_BLEND, 255, 255, 32'hfe_00_ff_00));
    send_item(make_item(KIND_READ, 255, 255, 32'h0));
    send_item(make_item(KIND_BLEND, 255, 0, 32'hff_00_00_00));
    send_item(make_item(KIND_BLEND, 0, 255, 32'h40_ff_ff_ff));
    // outside the tile
    send_item(make_item(KIND_BLEND, -1, 0, 32'hffffffff));
    send_item(make_item(KIND_BLEND, 0, 256, 32'hffffffff));
    send_item(make_item(KIND_READ, 32767, -32768, 32'h0));
    send_item(make_item(KIND_BLEND, -32768, 32767, 32'hffffffff));
    send_item(make_item(KIND_READ, 256, -1, 32'h0));
    drain();
  endtask

  task automatic test_opacity_extremes();
    write_reg(REG_OPACITY, 8'd0);
    send_item(make_item(KIND_BLEND, 1, 1, 32'hff_ff_ff_ff));    // zero output alpha
    send_item(make_item(KIND_BLEND, 0, 0, 32'hff_11_22_33));
    drain();
    write_reg(REG_OPACITY, 8'd1);
    send_item(make_item(KIND_BLEND, 2, 2, 32'hff_ff_ff_ff));
    drain();
    write_reg(8'd7, 8'd99);                                      // unknown register
    write_reg(REG_OPACITY, 8'd128);
    send_item(make_item(KIND_BLEND, 2, 2, 32'hff_00_80_ff));
    drain();
  endtask

  task automatic test_rgb_only();
    write_reg(REG_RGB_ONLY, 8'd1);
    send_item(make_item(KIND_BLEND, 0, 0, 32'h00_01_02_03));
    send_item(make_item(KIND_BLEND, 3, 3, 32'hff_ff_ff_ff));
    send_item(make_item(KIND_BLEND, -5, 3, 32'hff_ff_ff_ff));
    send_item(make_item(KIND_READ, 0, 0, 32'h0));
    drain();
    write_reg(REG_RGB_ONLY, 8'hfe);                              // upper bits dropped
    write_reg(REG_OPACITY, 8'd255);
    drain();
  endtask

  task automatic test_random();
    logic [7:0] op_set [6] = '{8'd255, 8'd0, 8'd1, 8'd200, 8'd77, 8'd255};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_OPACITY, (ph == 3) ? 8'($urandom) : op_set[ph]);
      write_reg(REG_RGB_ONLY, (ph == 2 || ph == 4) ? 8'd1 : 8'd0);
      calm = (ph == 1);
      for (int n = 0; n < 255; n++) begin
        if (n == 120) begin
          // hold off until the block has caught up
          start <= 1'b0;
          @(posedge clk);
          while (exp_wr != exp_rd) @(posedge clk);
        end
        send_item(random_item());
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < TILE_SIZE*TILE_SIZE; i++) tile_model[i] = '0;
    opacity_q = 8'd255;
    rgb_only_q = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_rgba();
    test_opacity_extremes();
    test_rgb_only();
    test_random();
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("alpha_blend_pixel_store verification clean");
    end else begin
      $display("alpha_blend_pixel_store verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
src/abps_pkg.sv
src/abps_div.sv
src/abps_dp.sv
src/abps_ctrl.sv
src/alpha_blend_pixel_store.sv
bench/alpha_blend_pixel_store_tb.sv
